>>> sv/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg - shared definitions for the LSB-first bit packer
// Command codes and packed payload widths of the stream channels.
// ----------------------------------------------------------------------------
package lbp_pkg;

    // Command codes carried on s_axis_tuser
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_SEEK  = 2'd2;

    // Field widths
    localparam int WORD_W   = 64;
    localparam int LEN_W    = 7;
    localparam int OFFSET_W = 22;
    localparam int ADDR_W   = 16;
    localparam int PTR_W    = 17;
    localparam int FILL_W   = 6;

    // Packed channel widths, rounded up to whole bytes
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 168;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [FILL_W-1:0] fill_t;

endpackage

>>> sv/lsb_first_bit_packer.sv
// ----------------------------------------------------------------------------
// lsb_first_bit_packer - variable-length field packer into 64-bit words
// Appends fields LSB first to a partial word, emits each completed word with
// its word address, and supports flush and seek commands.
// ----------------------------------------------------------------------------
//
//  Channel   | Direction | Payload
//  ----------+-----------+----------------------------------------------------
//  s_axis_*  | in        | tuser: cmd; tdata: value, length, seek offset
//  m_axis_*  | out       | tuser: word_valid, overflow; tdata: word, address,
//            |           |        leftover bits, size in words
//
//  One transaction per cycle is sustained while m_axis_tready stays high: an
//  accepted item is held in the input register, then a single shift-and-merge
//  pass over one 64-bit word updates the packer state and loads the result register.
//  aresetn clears the partial word, fill count, pointer and both valid flags.
//  A stall on m_axis_tready holds the result register and backs up into the
//  input register; s_axis_tready falls only when both are full.
//
module lsb_first_bit_packer
    import lbp_pkg::*;
#(
    parameter int CAPACITY_WORDS = 65536
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [63:0] field_value, [70:64] field_length, [92:71] seek_bit_offset,
    // [95:93] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] cmd
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [63:0] word_data, [79:64] word_address, [143:80] leftover_bits,
    // [160:144] size_in_words, [167:161] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // [0] word_valid, [1] overflow
    output logic [1:0]           m_axis_tuser
);

    localparam int CAP_W = 25;
    localparam logic [CAP_W-1:0] CAP_LIMIT = CAP_W'(CAPACITY_WORDS);

    // Input register
    logic                in_valid_reg;
    logic [1:0]          in_cmd_reg;
    word_t               in_value_reg;
    logic [LEN_W-1:0]    in_len_reg;
    logic [OFFSET_W-1:0] in_offset_reg;

    // Packer state
    word_t partial_reg, partial_next;
    fill_t fill_reg, fill_next;
    ptr_t  ptr_reg, ptr_next;

    // Result register
    logic              m_valid_reg;
    logic              word_valid_reg, word_valid_next;
    logic              overflow_reg, overflow_next;
    word_t             word_data_reg, word_data_next;
    logic [ADDR_W-1:0] word_addr_reg, word_addr_next;
    word_t             leftover_reg, leftover_next;
    ptr_t              size_reg;

    logic out_free;
    logic proc_fire;

    // Handshake: the result register frees when empty or taken
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign proc_fire     = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    // Capture the incoming transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            in_cmd_reg    <= s_axis_tuser;
            in_value_reg  <= s_axis_tdata[63:0];
            in_len_reg    <= s_axis_tdata[70:64];
            in_offset_reg <= s_axis_tdata[92:71];
        end
    end

    // Shift and merge
    logic [LEN_W-1:0] n_eff;
    logic             full_len;
    word_t            low_bits;
    word_t            merged;
    word_t            carry_bits;
    logic [LEN_W-1:0] total;
    logic             emit_cand;
    word_t            emit_word;
    logic             room_ok;

    always_comb begin
        n_eff    = (in_len_reg > LEN_W'(64)) ? LEN_W'(64) : in_len_reg;
        full_len = n_eff[6];
        low_bits = full_len ? in_value_reg
                            : (in_value_reg & ~({WORD_W{1'b1}} << n_eff[5:0]));
        merged   = partial_reg | (low_bits << fill_reg);
        carry_bits = (fill_reg == '0) ? '0 : (low_bits >> (FILL_W'(0) - fill_reg));
        total    = {1'b0, fill_reg} + n_eff;
        room_ok  = {{(CAP_W-PTR_W){1'b0}}, ptr_reg} < CAP_LIMIT;

        partial_next  = partial_reg;
        fill_next     = fill_reg;
        ptr_next      = ptr_reg;
        emit_cand     = 1'b0;
        emit_word     = merged;
        leftover_next = '0;

        case (in_cmd_reg)
            CMD_WRITE: begin
                emit_cand     = total[6];
                partial_next  = total[6] ? carry_bits : merged;
                fill_next     = total[5:0];
                leftover_next = full_len ? '0 : (in_value_reg >> n_eff[5:0]);
            end
            CMD_FLUSH: begin
                emit_cand    = (fill_reg != '0);
                emit_word    = partial_reg;
                partial_next = '0;
                fill_next    = '0;
            end
            CMD_SEEK: begin
                partial_next = '0;
                fill_next    = '0;
                ptr_next     = {1'b0, in_offset_reg[OFFSET_W-1:6]};
            end
            default: begin
            end
        endcase

        // Store the completed word, or drop it past capacity
        word_valid_next = emit_cand && room_ok;
        overflow_next   = emit_cand && !room_ok;
        word_data_next  = word_valid_next ? emit_word : '0;
        word_addr_next  = word_valid_next ? ptr_reg[ADDR_W-1:0] : '0;
        if (word_valid_next) begin
            ptr_next = ptr_reg + PTR_W'(1);
        end
    end

    // Advance state and load the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
            fill_reg    <= '0;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (proc_fire) begin
                partial_reg <= partial_next;
                fill_reg    <= fill_next;
                ptr_reg     <= ptr_next;
            end
            if (out_free) begin
                m_valid_reg <= in_valid_reg;
            end
        end
        if (proc_fire) begin
            word_valid_reg <= word_valid_next;
            overflow_reg   <= overflow_next;
            word_data_reg  <= word_data_next;
            word_addr_reg  <= word_addr_next;
            leftover_reg   <= leftover_next;
            size_reg       <= ptr_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = {overflow_reg, word_valid_reg};
    assign m_axis_tdata  = {7'd0, size_reg, leftover_reg, word_addr_reg, word_data_reg};

`ifndef SYNTHESIS
    // A word is either stored or dropped, never both
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(word_valid_reg && overflow_reg))
        else $error("word stored and flagged as overflow");

    // Flush and seek leave an empty partial word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && (in_cmd_reg == CMD_FLUSH || in_cmd_reg == CMD_SEEK))
        |=> (fill_reg == '0 && partial_reg == '0))
        else $error("partial word not cleared by flush or seek");

    // A stored word advances the pointer by exactly one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && word_valid_next) |=> (ptr_reg == $past(ptr_reg) + PTR_W'(1)))
        else $error("pointer did not advance after stored word");

    // Reported size matches the pointer right after processing
    assert property (@(posedge aclk) disable iff (!aresetn)
        proc_fire |=> (size_reg == ptr_reg))
        else $error("reported size differs from pointer");

    // No word data or address without a stored word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !word_valid_reg) |-> (word_data_reg == '0 && word_addr_reg == '0))
        else $error("word fields set without a stored word");
`endif

endmodule

>>> dv/lsb_first_bit_packer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_tb - self-checking bench for the LSB-first bit packer
// Drives write, flush, seek and unused commands on the input stream. Stalls
// both stream sides at random and predicts every result transaction with a
// behavioral copy of the packer state. Each result is compared field by
// field, in order, against the predicted one.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_tb;
    import lbp_pkg::*;

    localparam int         CAPACITY   = 65536;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam word_t      ALL_ONES   = {WORD_W{1'b1}};

    // One result transaction as carried on the master side
    typedef struct packed {
        logic               word_valid;
        logic               overflow;
        word_t              word_data;
        logic [ADDR_W-1:0]  word_address;
        word_t              leftover;
        ptr_t               size_words;
    } packer_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [63:0] field_value, [70:64] field_length, [92:71] seek_bit_offset,
    // [95:93] zero
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    // [1:0] cmd
    logic [1:0]           s_axis_tuser = CMD_WRITE;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [63:0] word_data, [79:64] word_address, [143:80] leftover_bits,
    // [160:144] size_in_words, [167:161] zero
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // [0] word_valid, [1] overflow
    logic [1:0]           m_axis_tuser;

    // Packer state mirrored by the predictor
    word_t                model_partial = '0;
    int unsigned          model_fill = 0;
    ptr_t                 model_ptr = '0;

    packer_result_t       pending_results[$];
    int                   send_idle_pct = 28;
    int                   recv_idle_pct = 58;
    int                   mismatch_count = 0;

    lsb_first_bit_packer #(
        .CAPACITY_WORDS(CAPACITY)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Advance the mirrored packer by one command and return its result
    function automatic packer_result_t predict_packer_step(logic [1:0] cmd, word_t value,
                                                           logic [LEN_W-1:0] len_in,
                                                           logic [OFFSET_W-1:0] offset);
        packer_result_t res;
        int unsigned    nbits;
        int unsigned    total;
        word_t          low;
        word_t          done_word;
        logic           have_word;
        res = '0;
        done_word = '0;
        have_word = 1'b0;
        // lengths above a full word saturate
        nbits = (len_in > 7'd64) ? 64 : int'(len_in);
        case (cmd)
            CMD_WRITE: begin
                if (nbits == 64) begin
                    if (model_fill == 0) begin
                        done_word = value;
                    end else begin
                        done_word = model_partial | (value << model_fill);
                        model_partial = value >> (64 - model_fill);
                    end
                    have_word = 1'b1;
                end else begin
                    res.leftover = value >> nbits;
                    low = value & ((64'd1 << nbits) - 64'd1);
                    total = model_fill + nbits;
                    model_partial |= low << model_fill;
                    if (total >= 64) begin
                        // spill the high part of the field into a fresh word
                        done_word = model_partial;
                        model_partial = low >> (64 - model_fill);
                        model_fill = total - 64;
                        have_word = 1'b1;
                    end else begin
                        model_fill = total;
                    end
                end
            end
            CMD_FLUSH: begin
                if (model_fill != 0) begin
                    done_word = model_partial;
                    model_partial = '0;
                    model_fill = 0;
                    have_word = 1'b1;
                end
            end
            CMD_SEEK: begin
                model_ptr = ptr_t'(offset >> 6);
                model_partial = '0;
                model_fill = 0;
            end
            default: begin
            end
        endcase
        // store the word, or drop it once the pointer reaches capacity
        if (have_word) begin
            if (int'(model_ptr) < CAPACITY) begin
                res.word_valid = 1'b1;
                res.word_data = done_word;
                res.word_address = model_ptr[ADDR_W-1:0];
                model_ptr = model_ptr + 1'b1;
            end else begin
                res.overflow = 1'b1;
            end
        end
        res.size_words = model_ptr;
        return res;
    endfunction

    function automatic word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, got);
    endtask

    // Send one command transaction; called and returning just after a falling edge
    task automatic send_item(logic [1:0] cmd, word_t value, logic [LEN_W-1:0] len,
                             logic [OFFSET_W-1:0] offset);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, offset, len, value};
        s_axis_tuser  <= cmd;
        do @(posedge aclk); while (!s_axis_tready);
        pending_results.push_back(predict_packer_step(cmd, value, len, offset));
        @(negedge aclk);
    endtask

    // Drop tready at random on each falling edge
    always @(negedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each accepted result transaction against the oldest prediction
    always @(posedge aclk) begin : check_results
        packer_result_t want;
        packer_result_t got;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.word_valid   = m_axis_tuser[0];
            got.overflow     = m_axis_tuser[1];
            got.word_data    = m_axis_tdata[63:0];
            got.word_address = m_axis_tdata[79:64];
            got.leftover     = m_axis_tdata[143:80];
            got.size_words   = m_axis_tdata[160:144];
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected transaction", '0, got.word_data);
            end else begin
                want = pending_results.pop_front();
                if (got.word_valid !== want.word_valid)
                    note_mismatch("word_valid", 64'(want.word_valid), 64'(got.word_valid));
                if (got.overflow !== want.overflow)
                    note_mismatch("overflow", 64'(want.overflow), 64'(got.overflow));
                if (got.word_data !== want.word_data)
                    note_mismatch("word_data", want.word_data, got.word_data);
                if (got.word_address !== want.word_address)
                    note_mismatch("word_address", 64'(want.word_address),
                                  64'(got.word_address));
                if (got.leftover !== want.leftover)
                    note_mismatch("leftover_bits", want.leftover, got.leftover);
                if (got.size_words !== want.size_words)
                    note_mismatch("size_in_words", 64'(want.size_words),
                                  64'(got.size_words));
            end
        end
    end

    // Field lengths at and around the word boundary, zero and saturated lengths
    task automatic test_write_extremes();
        send_item(CMD_WRITE, ALL_ONES, 7'd0, '0);
        send_item(CMD_WRITE, 64'd1, 7'd1, '0);
        send_item(CMD_WRITE, rand_word(), 7'd63, '0);
        send_item(CMD_WRITE, ALL_ONES, 7'd64, '0);
        send_item(CMD_WRITE, 64'h55, 7'd7, '0);
        send_item(CMD_WRITE, rand_word(), 7'd64, '0);
        send_item(CMD_WRITE, rand_word(), 7'd127, '0);
        send_item(CMD_WRITE, '0, 7'd65, '0);
        send_item(CMD_WRITE, rand_word(), 7'd50, '0);
    endtask

    // Flush of a partial word, then of an empty one
    task automatic test_flush();
        send_item(CMD_FLUSH, ALL_ONES, 7'd127, {OFFSET_W{1'b1}});
        send_item(CMD_FLUSH, '0, 7'd0, '0);
    endtask

    // Seek to the last word, fill it, then run past capacity
    task automatic test_seek_overflow();
        send_item(CMD_SEEK, '0, 7'd0, {OFFSET_W{1'b1}});
        send_item(CMD_WRITE, rand_word(), 7'd64, '0);
        send_item(CMD_WRITE, rand_word(), 7'd64, '0);
        send_item(CMD_WRITE, rand_word(), 7'd40, '0);
        send_item(CMD_WRITE, rand_word(), 7'd40, '0);
        send_item(CMD_WRITE, rand_word(), 7'd48, '0);
        send_item(CMD_WRITE, rand_word(), 7'd20, '0);
        send_item(CMD_FLUSH, '0, 7'd0, '0);
        send_item(CMD_SEEK, '0, 7'd0, 22'd63);
    endtask

    // Unused command leaves the partial word alone
    task automatic test_unused_command();
        send_item(CMD_UNUSED, ALL_ONES, 7'd127, {OFFSET_W{1'b1}});
        send_item(CMD_WRITE, rand_word(), 7'd10, '0);
        send_item(CMD_UNUSED, rand_word(), 7'd64, 22'd12345);
        send_item(CMD_FLUSH, '0, 7'd0, '0);
    endtask

    // Mostly writes of random length, with flushes, seeks and some noise
    task automatic test_random_traffic(int count, int send_pct, int recv_pct);
        int                  sent;
        int                  pick;
        int                  len_pick;
        logic [LEN_W-1:0]    len;
        logic [OFFSET_W-1:0] offset;
        word_t               value;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            len_pick = $urandom_range(9);
            value = ($urandom_range(19) == 0) ? (($urandom_range(1) == 0) ? '0 : ALL_ONES)
                                               : rand_word();
            case (len_pick)
                0:       len = ($urandom_range(1) == 0) ? 7'd0 : 7'd64;
                1:       len = LEN_W'($urandom_range(65, 127));
                default: len = LEN_W'($urandom_range(1, 63));
            endcase
            case ($urandom_range(3))
                0:       offset = OFFSET_W'($urandom_range(65528 * 64, 4194303));
                1:       offset = OFFSET_W'($urandom_range(0, 2047));
                default: offset = OFFSET_W'($urandom);
            endcase
            if (pick < 72) begin
                send_item(CMD_WRITE, value, len, offset);
                sent++;
            end else if (pick < 84) begin
                send_item(CMD_FLUSH, value, len, offset);
                sent++;
            end else if (pick < 96) begin
                send_item(CMD_SEEK, value, len, offset);
                sent++;
            end else begin
                send_item(CMD_UNUSED, value, len, offset);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_write_extremes();
        test_flush();
        test_seek_overflow();
        test_unused_command();
        test_random_traffic(370, 28, 58);
        test_random_traffic(370, 58, 28);
        test_random_traffic(370, 0, 0);

        // Drain the result stream, then watch for stray transactions
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
